// ===== hdl/rational_arithmetic_unit_core_assert.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("rational arithmetic unit: same-cycle check failed");
`define RAU_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("rational arithmetic unit: next-cycle check failed");
`else
`define RAU_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons)
`define RAU_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

// ===== hdl/rau_pkg.sv =====
// Types, operation codes and helpers for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// Four products go through the shared multiplier.
	localparam logic [1:0] MUL_LAST = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic               error;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
	} rau_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_COMBINE,
		ST_GCD_TWOS,
		ST_GCD_LOOP,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_FINISH
	} rau_state_t;

	// Magnitude of a two's complement word; the most negative value gives 2^31.
	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: exact add, subtract, multiply, divide and compare of fractions.
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
// Usage notes.
// An item on the input channel (in_valid/in_ready/in_data) carries an operation code
// and two signed fractions. One result item leaves on the output channel
// (out_valid/out_ready/out_data): the reduced result with its sign on the numerator and
// a positive denominator, an error flag, and exact less, equal and greater flags.
// The block works on one item at a time. in_ready is high only while it is idle.
// Steps of one item: an item with a zero denominator goes straight to the step that
// loads the output register. Otherwise the item goes through the shared 32x32
// multiplier for its four products, a combine and compare step, a binary GCD (at most
// one 64-bit compare and subtract per cycle), two restoring divisions and a final step
// that loads the output register. A divide by zero goes from the combine step straight
// to loading the output register. The next item is accepted in the cycle after the
// previous result moves into the output register.
// The output register decouples the two sides: a new item is taken while the previous
// result still waits. If the receiver stalls long enough, the finished item waits in
// its last state until the output register frees, and in_ready stays low meanwhile.
// Reset (arst_n low) returns the sequencer to idle and empties the output register.
module rational_arithmetic_unit_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rau_pkg::rau_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rau_pkg::rau_out_t      out_data
);
	import rau_pkg::*;

	rau_state_t state_q, state_next;

	// Operand magnitudes and signs captured at acceptance.
	logic [1:0]  func_q;
	logic [31:0] na_q, da_q, nb_q, db_q;
	logic        sa_q, sb_q;
	logic        err_q;
	logic        lt_q, eq_q, gt_q;

	// Products: p1 = na*db, p2 = nb*da, p3 = na*nb, p4 = result denominator.
	logic [1:0]  mul_cnt_q;
	logic [63:0] p1_q, p2_q, p3_q, p4_q;
	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_prod;

	// Unreduced result, GCD working pair and divider.
	logic [63:0] rmag_q, rden_q;
	logic        rsign_q;
	logic [63:0] u_q, v_q;
	logic [5:0]  k_q;
	logic [63:0] dq_q, rem_q, qn_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic        out_valid_q;
	rau_out_t    out_data_q;

	logic        in_den_zero;
	logic        out_load;

	// Combine stage signals.
	logic signed [63:0] cmp_l, cmp_r;
	logic        div_zero;
	logic        s2;
	logic [63:0] cmb_mag;
	logic        cmb_sign;

	// Subtract path signals for the GCD and the divider.
	logic        gcd_ge;
	logic [63:0] gcd_diff;
	logic [64:0] div_trial;
	logic        div_bit;
	logic [63:0] div_rem;

	// Final formatting.
	logic [63:0] fin_num;
	logic        fin_sign;

	assign in_den_zero = (in_data.a_den == 32'sd0) || (in_data.b_den == 32'sd0);

	// The single multiplier is stepped through the four products by mul_cnt_q.
	always_comb begin
		mul_x = na_q;
		mul_y = db_q;
		case (mul_cnt_q)
			2'd0: begin
				mul_x = na_q;
				mul_y = db_q;
			end
			2'd1: begin
				mul_x = nb_q;
				mul_y = da_q;
			end
			2'd2: begin
				mul_x = na_q;
				mul_y = nb_q;
			end
			default: begin
				mul_x = da_q;
				mul_y = (func_q == FUNC_DIV) ? nb_q : db_q;
			end
		endcase
	end

	assign mul_prod = 64'(mul_x) * 64'(mul_y);

	// Exact comparison works on the signed cross products, whose magnitudes stay
	// within 2^62. The same stage forms the unreduced numerator magnitude and sign.
	always_comb begin
		cmp_l = sa_q ? -$signed(p1_q) : $signed(p1_q);
		cmp_r = sb_q ? -$signed(p2_q) : $signed(p2_q);
		div_zero = (func_q == FUNC_DIV) && (nb_q == 32'd0);
		s2 = (func_q == FUNC_SUB) ? !sb_q : sb_q;
		if (nb_q == 32'd0) begin
			s2 = 1'b0;
		end
		cmb_mag = p1_q;
		cmb_sign = sa_q ^ sb_q;
		if (func_q == FUNC_ADD || func_q == FUNC_SUB) begin
			if (sa_q == s2) begin
				cmb_mag = p1_q + p2_q;
				cmb_sign = sa_q;
			end else if (p1_q >= p2_q) begin
				cmb_mag = p1_q - p2_q;
				cmb_sign = sa_q;
			end else begin
				cmb_mag = p2_q - p1_q;
				cmb_sign = s2;
			end
		end else if (func_q == FUNC_MUL) begin
			cmb_mag = p3_q;
		end else begin
			cmb_mag = p1_q;
		end
	end

	// Binary GCD step: when both values are odd, the larger is replaced by half the
	// difference, which is always even.
	assign gcd_ge = u_q >= v_q;
	assign gcd_diff = gcd_ge ? (u_q - v_q) : (v_q - u_q);

	// Restoring division step; v_q holds the divisor (the GCD) here.
	assign div_trial = {rem_q, dq_q[63]} - {1'b0, v_q};
	assign div_bit = !div_trial[64];
	assign div_rem = div_bit ? div_trial[63:0] : {rem_q[62:0], dq_q[63]};

	assign fin_sign = rsign_q && (qn_q != 64'd0);
	assign fin_num = fin_sign ? (64'd0 - qn_q) : qn_q;

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_next = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_next = in_den_zero ? ST_FINISH : ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_cnt_q == MUL_LAST) begin
					state_next = ST_COMBINE;
				end
			end
			ST_COMBINE: begin
				state_next = div_zero ? ST_FINISH : ST_GCD_TWOS;
			end
			ST_GCD_TWOS: begin
				if (u_q == 64'd0) begin
					state_next = ST_DIV_NUM;
				end else if (u_q[0] || v_q[0]) begin
					state_next = ST_GCD_LOOP;
				end
			end
			ST_GCD_LOOP: begin
				if (u_q == 64'd0) begin
					state_next = ST_DIV_NUM;
				end
			end
			ST_DIV_NUM: begin
				if (div_cnt_q == DIV_LAST) begin
					state_next = ST_DIV_DEN;
				end
			end
			ST_DIV_DEN: begin
				if (div_cnt_q == DIV_LAST) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Datapath registers and step counters; each is loaded before use, so none needs a reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q <= in_data.func;
					na_q <= mag32(in_data.a_num);
					da_q <= mag32(in_data.a_den);
					nb_q <= mag32(in_data.b_num);
					db_q <= mag32(in_data.b_den);
					sa_q <= in_data.a_num[31] ^ in_data.a_den[31];
					sb_q <= in_data.b_num[31] ^ in_data.b_den[31];
					err_q <= in_den_zero;
					lt_q <= 1'b0;
					eq_q <= 1'b0;
					gt_q <= 1'b0;
					mul_cnt_q <= 2'd0;
				end
			end
			ST_MUL: begin
				case (mul_cnt_q)
					2'd0: p1_q <= mul_prod;
					2'd1: p2_q <= mul_prod;
					2'd2: p3_q <= mul_prod;
					default: p4_q <= mul_prod;
				endcase
				mul_cnt_q <= mul_cnt_q + 2'd1;
			end
			ST_COMBINE: begin
				lt_q <= cmp_l < cmp_r;
				eq_q <= cmp_l == cmp_r;
				gt_q <= cmp_l > cmp_r;
				err_q <= div_zero;
				rmag_q <= cmb_mag;
				rden_q <= p4_q;
				rsign_q <= cmb_sign;
				u_q <= cmb_mag;
				v_q <= p4_q;
				k_q <= 6'd0;
			end
			ST_GCD_TWOS: begin
				if (u_q == 64'd0) begin
					v_q <= v_q << k_q;
					dq_q <= rmag_q;
					rem_q <= 64'd0;
					div_cnt_q <= '0;
				end else if (!(u_q[0] || v_q[0])) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 6'd1;
				end
			end
			ST_GCD_LOOP: begin
				if (u_q == 64'd0) begin
					v_q <= v_q << k_q;
					dq_q <= rmag_q;
					rem_q <= 64'd0;
					div_cnt_q <= '0;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (gcd_ge) begin
					u_q <= gcd_diff >> 1;
				end else begin
					v_q <= gcd_diff >> 1;
				end
			end
			ST_DIV_NUM: begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_LAST) begin
					qn_q <= {dq_q[62:0], div_bit};
					dq_q <= rden_q;
					rem_q <= 64'd0;
				end else begin
					dq_q <= {dq_q[62:0], div_bit};
					rem_q <= div_rem;
				end
			end
			ST_DIV_DEN: begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				dq_q <= {dq_q[62:0], div_bit};
				rem_q <= div_rem;
			end
			ST_FINISH: begin
				if (out_load) begin
					out_data_q.error <= err_q;
					out_data_q.a_less <= lt_q;
					out_data_q.a_equal <= eq_q;
					out_data_q.a_greater <= gt_q;
					if (err_q) begin
						out_data_q.res_num <= 64'sd0;
						out_data_q.res_den <= 63'd0;
					end else begin
						out_data_q.res_num <= $signed(fin_num);
						out_data_q.res_den <= dq_q[62:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when the finished item moves in, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`RAU_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready,
		state_q == ST_MUL || state_q == ST_FINISH)
	`RAU_ASSERT_SAME(a_error_zero, clk, arst_n, out_valid && out_data.error,
		out_data.res_num == 64'sd0 && out_data.res_den == 63'd0)
	`RAU_ASSERT_SAME(a_den_positive, clk, arst_n, out_valid && !out_data.error,
		out_data.res_den != 63'd0)
	`RAU_ASSERT_SAME(a_flags_exclusive, clk, arst_n, out_valid,
		$onehot0({out_data.a_less, out_data.a_equal, out_data.a_greater}))
	`RAU_ASSERT_SAME(a_divisor_nonzero, clk, arst_n,
		state_q == ST_DIV_NUM || state_q == ST_DIV_DEN, v_q != 64'd0)

endmodule
`default_nettype wire

// ===== test/rau_result_checker.sv =====
// Result checker for the rational arithmetic unit: predicts every item and compares results.
`timescale 1ns / 100ps
module rau_result_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_ready,
	input  rau_pkg::rau_in_t   in_data,
	input  wire logic          out_valid,
	input  wire logic          out_ready,
	input  rau_pkg::rau_out_t  out_data,
	output int                 bad_count,
	output int                 due_count
);
	import rau_pkg::*;

	// The counters are two-state and start at zero.
	rau_out_t fractions_due[$];
	int       results_seen;

	function automatic logic [63:0] wide_mag(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = v;
		return (w < 0) ? 64'(-w) : 64'(w);
	endfunction

	function automatic logic [63:0] common_divisor(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 64'd0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Exact result of one item, with the sign carried on the numerator.
	function automatic rau_out_t reduce_fraction_op(input rau_in_t op);
		logic [63:0]        na, da, nb, db, t1, t2, mag, den, g;
		logic signed [63:0] lhs, rhs;
		logic               sa, sb, s2, neg, bad;
		rau_out_t           r;
		r = '0;
		sa = op.a_num[31] ^ op.a_den[31];
		sb = op.b_num[31] ^ op.b_den[31];
		na = wide_mag(op.a_num);
		da = wide_mag(op.a_den);
		nb = wide_mag(op.b_num);
		db = wide_mag(op.b_den);
		mag = '0;
		den = '0;
		neg = 1'b0;
		bad = 1'b0;
		if (da == 64'd0 || db == 64'd0) begin
			bad = 1'b1;
		end else begin
			lhs = na * db;
			rhs = nb * da;
			if (sa) lhs = -lhs;
			if (sb) rhs = -rhs;
			r.a_less = lhs < rhs;
			r.a_equal = lhs == rhs;
			r.a_greater = lhs > rhs;
			case (op.func)
				FUNC_ADD, FUNC_SUB: begin
					t1 = na * db;
					t2 = nb * da;
					s2 = (op.func == FUNC_SUB) ? !sb : sb;
					if (nb == 64'd0) s2 = 1'b0;
					if (sa == s2) begin
						mag = t1 + t2;
						neg = sa;
					end else if (t1 >= t2) begin
						mag = t1 - t2;
						neg = sa;
					end else begin
						mag = t2 - t1;
						neg = s2;
					end
					den = da * db;
				end
				FUNC_MUL: begin
					mag = na * nb;
					den = da * db;
					neg = sa ^ sb;
				end
				FUNC_DIV: begin
					if (nb == 64'd0) begin
						bad = 1'b1;
					end else begin
						mag = na * db;
						den = da * nb;
						neg = sa ^ sb;
					end
				end
			endcase
			if (!bad) begin
				g = common_divisor(mag, den);
				mag = mag / g;
				den = den / g;
				if (mag == 64'd0) neg = 1'b0;
			end
		end
		if (bad) begin
			mag = '0;
			den = '0;
			neg = 1'b0;
		end
		r.res_num = neg ? -mag : mag;
		r.res_den = den[62:0];
		r.error = bad;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: result %0d: %s", $time, results_seen, msg);
		bad_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
	endtask

	always @(posedge clk) begin
		rau_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (fractions_due.size() == 0) begin
					flag_mismatch($sformatf("result %h arrived with no item owed", out_data));
				end else begin
					want = fractions_due.pop_front();
					check_field("res_num", out_data.res_num, want.res_num);
					check_field("res_den", 64'(out_data.res_den), 64'(want.res_den));
					check_field("error", 64'(out_data.error), 64'(want.error));
					check_field("a_less", 64'(out_data.a_less), 64'(want.a_less));
					check_field("a_equal", 64'(out_data.a_equal), 64'(want.a_equal));
					check_field("a_greater", 64'(out_data.a_greater), 64'(want.a_greater));
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				fractions_due.push_back(reduce_fraction_op(in_data));
			due_count = fractions_due.size();
		end
	end

endmodule

// ===== test/tb_rational_arithmetic_unit_core.sv =====
// Testbench top for the rational arithmetic unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_rational_arithmetic_unit_core;
	import rau_pkg::*;

	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

	// Number of random items after the directed ones.
	localparam int RANDOM_ITEMS = 650;
	// The sender waits for the unit to drain completely before this random item.
	localparam int DRAIN_AT = 400;
	// After this many results the receiver refuses results for a long stretch.
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 1500;
	// No idling for random items with this index, nor stalls for results with this count.
	localparam int BURST_LO = 250;
	localparam int BURST_HI = 350;
	// The tail after the last owed result leaves room for stray results.
	localparam int TAIL_CYCLES = 400;
	// The long hold-off is the longest honest stretch without a handshake.
	localparam int IDLE_LIMIT = 5000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	rau_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	rau_out_t out_data;
	int       bad_count;
	int       due_count;

	// Sender-side idling switch; the receiver keeps its own.
	bit       send_idling;

	rational_arithmetic_unit_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	rau_result_checker checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.bad_count (bad_count),
		.due_count (due_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Offers one item. It is entered and left at a falling edge. When the next item
	// follows with no gap, valid simply stays high and only the payload changes, so
	// valid never gets two assignments in one time step.
	task automatic offer(input rau_in_t item);
		int gap;
		gap = send_idling ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer_fields(input logic [1:0] func, input logic signed [31:0] an,
			input logic signed [31:0] ad, input logic signed [31:0] bn,
			input logic signed [31:0] bd);
		rau_in_t item;
		item.func = func;
		item.a_num = an;
		item.a_den = ad;
		item.b_num = bn;
		item.b_den = bd;
		offer(item);
	endtask

	// One operand word. Small values make reductions and ties likely, full-width
	// words toggle every bit, and the extremes include the most negative value.
	function automatic logic [31:0] draw_word(input bit nonzero);
		logic [31:0] w;
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = $urandom_range(0, 40) - 20;
			4, 5, 6:    w = r;
			7:          w = {{16{r[15]}}, r[15:0]};
			8: begin
				case ($urandom_range(0, 4))
					0:       w = WORD_MIN;
					1:       w = WORD_MAX;
					2:       w = -WORD_MAX;
					3:       w = 32'd1;
					default: w = 32'hffff_ffff;
				endcase
			end
			default:    w = '0;
		endcase
		if (nonzero && w == '0) w = r[0] ? 32'd3 : 32'hffff_fffd;
		return w;
	endfunction

	// Mostly well-formed items with random content; a share of equal operands,
	// zero denominators and zero second numerators steers into the special cases.
	function automatic rau_in_t random_item();
		rau_in_t item;
		int      shape;
		int      k;
		int      base_num;
		int      base_den;
		item.func = 2'($urandom_range(0, 3));
		item.a_num = draw_word(1'b0);
		item.a_den = draw_word(1'b1);
		item.b_num = draw_word(1'b0);
		item.b_den = draw_word(1'b1);
		shape = $urandom_range(0, 99);
		if (shape < 10) begin
			// Same value written two ways, so the equal flag is exercised.
			base_num = int'($urandom_range(0, 2000)) - 1000;
			base_den = int'($urandom_range(1, 1000));
			if ($urandom_range(0, 1) == 1) base_den = -base_den;
			k = int'($urandom_range(1, 50));
			if ($urandom_range(0, 1) == 1) k = -k;
			item.a_num = base_num;
			item.a_den = base_den;
			item.b_num = base_num * k;
			item.b_den = base_den * k;
		end else if (shape < 13) begin
			item.a_den = '0;
		end else if (shape < 16) begin
			item.b_den = '0;
		end else if (shape < 18) begin
			item.a_den = '0;
			item.b_den = '0;
		end else if (shape < 26) begin
			item.b_num = '0;
		end
		return item;
	endfunction

	// Stimulus: reset, directed items, then the random part.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idling = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Plain cases of every operation, with a zero result and mixed signs.
		offer_fields(FUNC_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
		offer_fields(FUNC_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
		offer_fields(FUNC_MUL, -32'sd3, 32'sd4, 32'sd4, -32'sd3);
		offer_fields(FUNC_DIV, 32'sd5, -32'sd7, -32'sd10, 32'sd14);
		offer_fields(FUNC_SUB, 32'sd1, 32'sd3, 32'sd1, 32'sd2);
		offer_fields(FUNC_ADD, 32'sd2, 32'sd4, -32'sd3, -32'sd6);
		offer_fields(FUNC_MUL, 32'sd0, -32'sd9, 32'sd7, 32'sd3);
		offer_fields(FUNC_DIV, -32'sd1, 32'sd1, 32'sd1, -32'sd1);
		offer_fields(FUNC_ADD, 32'sd0, WORD_MIN, 32'sd0, 32'sd1);
		// Zero denominators on either side and on both.
		offer_fields(FUNC_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd2);
		offer_fields(FUNC_SUB, 32'sd5, 32'sd3, 32'sd1, 32'sd0);
		offer_fields(FUNC_MUL, WORD_MAX, 32'sd0, WORD_MIN, 32'sd0);
		offer_fields(FUNC_DIV, 32'sd0, 32'sd0, 32'sd0, 32'sd1);
		// Divide by a zero fraction: error, but the comparison still holds.
		offer_fields(FUNC_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd5);
		offer_fields(FUNC_DIV, 32'sd0, -32'sd5, 32'sd0, 32'sd7);
		// The most negative word and the largest magnitudes.
		offer_fields(FUNC_ADD, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		offer_fields(FUNC_MUL, WORD_MIN, 32'sd1, WORD_MIN, 32'sd1);
		offer_fields(FUNC_DIV, WORD_MIN, 32'sd1, 32'sd1, WORD_MIN);
		offer_fields(FUNC_SUB, WORD_MAX, 32'sd1, WORD_MIN, 32'sd1);
		offer_fields(FUNC_ADD, WORD_MAX, WORD_MAX - 32'sd1, -WORD_MAX, WORD_MAX);
		offer_fields(FUNC_MUL, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
		offer_fields(FUNC_DIV, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
		offer_fields(FUNC_SUB, WORD_MIN, -32'sd1, WORD_MAX, 32'sd3);

		// Let the directed part drain before the random items start.
		in_valid <= 1'b0;
		while (due_count != 0) @(negedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_idling = !(i >= BURST_LO && i < BURST_HI);
			if (i == DRAIN_AT) begin
				// Pause until every owed result has come back, then resume.
				in_valid <= 1'b0;
				while (due_count != 0) @(negedge clk);
				@(negedge clk);
			end
			offer(random_item());
		end
		in_valid <= 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (bad_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: a random stall before each result, a burst window without stalls,
	// and one long hold-off that fills the unit and pushes back on the sender.
	initial begin
		int  stall;
		int  hold_left;
		int  taken;
		bit  took;
		bit  recv_idling;
		out_ready = 1'b0;
		stall = 0;
		hold_left = 0;
		taken = 0;
		forever begin
			@(posedge clk);
			took = out_valid && out_ready;
			@(negedge clk);
			if (took) begin
				taken++;
				recv_idling = !(taken >= BURST_LO && taken < BURST_HI);
				stall = recv_idling ? $urandom_range(0, 5) : 0;
				if (taken == HOLD_AT) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
